@@ rtl/hhth_pkg.sv @@
// ----------------------------------------------------------------------------
// hhth_pkg
// Types, constants and helpers shared by the request head hasher modules.
// ----------------------------------------------------------------------------
package hhth_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] FOLD_MULT = 32'd2654435761;
	localparam logic [31:0] TAG_MULT  = 32'd40503;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_COLON = 8'd58;

	typedef enum logic [2:0] {
		CL_SPACE,
		CL_CR,
		CL_LF,
		CL_COLON,
		CL_OTHER
	} class_t;

	typedef enum logic [3:0] {
		M_METHOD,
		M_TARGET,
		M_VERSION,
		M_LINE_CR,
		M_LINE_START,
		M_NAME,
		M_GAP,
		M_VALUE,
		M_BLANK_CR,
		M_DONE,
		M_BAD
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_HASH,
		OP_START,
		OP_FOLD_METHOD,
		OP_FOLD_TARGET,
		OP_FOLD_NAME,
		OP_FOLD_VALUE
	} op_t;

	typedef struct packed {
		logic [7:0] data;
		op_t        op;
		logic       last;
		logic       done;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic class_t byte_class(input logic [7:0] b);
		class_t k;
		case (b)
			CH_SPACE: k = CL_SPACE;
			CH_CR:    k = CL_CR;
			CH_LF:    k = CL_LF;
			CH_COLON: k = CL_COLON;
			default:  k = CL_OTHER;
		endcase
		return k;
	endfunction

	// tag * TAG_MULT for the token kinds, worked out at elaboration
	function automatic logic [31:0] tag_term(input op_t op);
		logic [31:0] t;
		case (op)
			OP_FOLD_METHOD: t = 32'(TAG_MULT * 32'd1);
			OP_FOLD_TARGET: t = 32'(TAG_MULT * 32'd2);
			OP_FOLD_NAME:   t = 32'(TAG_MULT * 32'd3);
			OP_FOLD_VALUE:  t = 32'(TAG_MULT * 32'd4);
			default:        t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/hhth_front.sv @@
// ----------------------------------------------------------------------------
// hhth_front
// Accepts head bytes, classes them and steps the parse mode machine; emits
// one hashing operation per byte into the queue.
// ----------------------------------------------------------------------------
module hhth_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          head_byte,
	input  logic                last_byte,
	input  hhth_pkg::qstat_t    q_stat,
	output logic                push,
	output hhth_pkg::item_t     item
);

	hhth_pkg::mode_t  mode_q;
	hhth_pkg::mode_t  mode_step;
	hhth_pkg::mode_t  mode_next;
	hhth_pkg::op_t    op;
	hhth_pkg::class_t k;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hhth_pkg::M_METHOD;
		end else begin
			mode_q <= mode_next;
		end
	end

	always_comb begin
		k         = hhth_pkg::byte_class(head_byte);
		mode_step = mode_q;
		op        = hhth_pkg::OP_NONE;
		case (mode_q)
			hhth_pkg::M_METHOD: begin
				if (k == hhth_pkg::CL_SPACE) begin
					op        = hhth_pkg::OP_FOLD_METHOD;
					mode_step = hhth_pkg::M_TARGET;
				end else begin
					op = hhth_pkg::OP_HASH;
				end
			end
			hhth_pkg::M_TARGET: begin
				if (k == hhth_pkg::CL_SPACE) begin
					op        = hhth_pkg::OP_FOLD_TARGET;
					mode_step = hhth_pkg::M_VERSION;
				end else begin
					op = hhth_pkg::OP_HASH;
				end
			end
			hhth_pkg::M_VERSION: begin
				if (k == hhth_pkg::CL_CR) mode_step = hhth_pkg::M_LINE_CR;
			end
			hhth_pkg::M_LINE_CR: begin
				mode_step = (k == hhth_pkg::CL_LF) ? hhth_pkg::M_LINE_START : hhth_pkg::M_BAD;
			end
			hhth_pkg::M_LINE_START: begin
				if (k == hhth_pkg::CL_CR) begin
					mode_step = hhth_pkg::M_BLANK_CR;
				end else begin
					op        = hhth_pkg::OP_START;
					mode_step = hhth_pkg::M_NAME;
				end
			end
			hhth_pkg::M_NAME: begin
				if (k == hhth_pkg::CL_COLON) begin
					op        = hhth_pkg::OP_FOLD_NAME;
					mode_step = hhth_pkg::M_GAP;
				end else begin
					op = hhth_pkg::OP_HASH;
				end
			end
			hhth_pkg::M_GAP: begin
				if (k == hhth_pkg::CL_CR) begin
					mode_step = hhth_pkg::M_LINE_CR;
				end else if (k != hhth_pkg::CL_SPACE) begin
					op        = hhth_pkg::OP_START;
					mode_step = hhth_pkg::M_VALUE;
				end
			end
			hhth_pkg::M_VALUE: begin
				if (k == hhth_pkg::CL_CR) begin
					op        = hhth_pkg::OP_FOLD_VALUE;
					mode_step = hhth_pkg::M_LINE_CR;
				end else begin
					op = hhth_pkg::OP_HASH;
				end
			end
			hhth_pkg::M_BLANK_CR: begin
				mode_step = (k == hhth_pkg::CL_LF) ? hhth_pkg::M_DONE : hhth_pkg::M_BAD;
			end
			default: begin
				mode_step = mode_q;
			end
		endcase

		mode_next = mode_q;
		if (push) mode_next = last_byte ? hhth_pkg::M_METHOD : mode_step;

		item.data = head_byte;
		item.op   = op;
		item.last = last_byte;
		item.done = (mode_step == hhth_pkg::M_DONE);
	end

endmodule

@@ rtl/hhth_queue.sv @@
// ----------------------------------------------------------------------------
// hhth_queue
// Two-entry queue of hashing operations between the front and back parts.
// ----------------------------------------------------------------------------
module hhth_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hhth_pkg::item_t     wr_item,
	input  logic                pop,
	output hhth_pkg::item_t     rd_item,
	output hhth_pkg::qstat_t    q_stat
);

	hhth_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign rd_item      = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/hhth_back.sv @@
// ----------------------------------------------------------------------------
// hhth_back
// Runs the FNV-1a token hash and the multiply-xor fold, and holds the result
// of each head in an output register.
// ----------------------------------------------------------------------------
module hhth_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hhth_pkg::qstat_t    q_stat,
	input  hhth_pkg::item_t     item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         head_checksum,
	output logic                head_complete,
	output logic [31:0]         running_total
);

	logic [31:0] hash_q;
	logic [31:0] fold_q;
	logic [31:0] total_q;
	logic        out_valid_q;
	logic [31:0] checksum_q;
	logic        complete_q;

	logic [31:0] hash_in;
	logic [31:0] hash_new;
	logic [31:0] fold_new;
	logic [31:0] sum;
	logic        is_fold;

	assign pop = !q_stat.empty && (!item.last || !out_valid_q || !out_stall);

	always_comb begin
		hash_in  = ((item.op == hhth_pkg::OP_START) ? hhth_pkg::FNV_BASIS : hash_q)
			^ {24'd0, item.data};
		hash_new = hash_in * hhth_pkg::FNV_PRIME;
		fold_new = (fold_q * hhth_pkg::FOLD_MULT) ^ (hhth_pkg::tag_term(item.op) + hash_q);
		sum      = item.done ? fold_q : 32'd0;
		is_fold  = (item.op == hhth_pkg::OP_FOLD_METHOD) || (item.op == hhth_pkg::OP_FOLD_TARGET)
			|| (item.op == hhth_pkg::OP_FOLD_NAME) || (item.op == hhth_pkg::OP_FOLD_VALUE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= hhth_pkg::FNV_BASIS;
			fold_q      <= 32'd0;
			total_q     <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (item.last) begin
					hash_q  <= hhth_pkg::FNV_BASIS;
					fold_q  <= 32'd0;
					total_q <= total_q + sum;
				end else begin
					if (item.op == hhth_pkg::OP_HASH || item.op == hhth_pkg::OP_START) begin
						hash_q <= hash_new;
					end
					if (is_fold) fold_q <= fold_new;
					if (item.op == hhth_pkg::OP_FOLD_METHOD) hash_q <= hhth_pkg::FNV_BASIS;
				end
			end
		end
	end

	// a complete head ends in the done mode, which never folds, so the fold register is final
	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			checksum_q <= sum;
			complete_q <= item.done;
		end
	end

	assign out_valid     = out_valid_q;
	assign head_checksum = checksum_q;
	assign head_complete = complete_q;
	assign running_total = total_q;

endmodule

@@ rtl/http_head_token_hasher_unit.sv @@
// After its last byte, a head's result passes through the queue and the output register.
// Throughput: one byte per cycle while in_stall is low; the hash multiply loop sets it.
// The two-entry queue lets bytes keep coming while a result waits on out_stall.
// Reset: arst_n clears the parse mode, the queue, token hash and fold, and the running total.
// ----------------------------------------------------------------------------
// http_head_token_hasher_unit
// HTTP request head parser that folds FNV-1a hashes of its tokens into a
// checksum per head and a running total.
// ----------------------------------------------------------------------------
module http_head_token_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  head_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] head_checksum,
	output logic        head_complete,
	output logic [31:0] running_total
);

	hhth_pkg::qstat_t q_stat;
	hhth_pkg::item_t  wr_item;
	hhth_pkg::item_t  rd_item;
	logic             push;
	logic             pop;

	hhth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.head_byte (head_byte),
		.last_byte (last_byte),
		.q_stat    (q_stat),
		.push      (push),
		.item      (wr_item)
	);

	hhth_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.q_stat  (q_stat)
	);

	hhth_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.item          (rd_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.head_checksum (head_checksum),
		.head_complete (head_complete),
		.running_total (running_total)
	);

`ifndef SYNTHESIS
	a_incomplete_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !head_complete) |-> (head_checksum == 32'd0))
		else $error("incomplete head with nonzero checksum");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("back part read an empty queue");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (!push && !q_stat.empty))
		else $error("front pushed into a full queue");

	a_total_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !(pop && rd_item.last)) |=> $stable(running_total))
		else $error("running total moved without a new head result");
`endif

endmodule

@@ sim/hhth_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hhth_checker
// Follows every byte transfer into the head hasher, parses and hashes the
// head alongside it, and compares each result transfer field by field with
// the oldest outstanding head result.
// ----------------------------------------------------------------------------
module hhth_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  head_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] head_checksum,
	input  logic        head_complete,
	input  logic [31:0] running_total,
	output int          fail_count,
	output int          pending
);
	import hhth_pkg::*;

	localparam logic [31:0] TAG_METHOD = 32'd1;
	localparam logic [31:0] TAG_TARGET = 32'd2;
	localparam logic [31:0] TAG_NAME   = 32'd3;
	localparam logic [31:0] TAG_VALUE  = 32'd4;

	typedef struct packed {
		logic [31:0] checksum;
		logic        complete;
		logic [31:0] total;
	} head_result_t;

	head_result_t head_results[$];

	mode_t       mode;
	logic [31:0] tok_hash;
	logic [31:0] tok_fold;
	logic [31:0] sum_total;
	int          errs;

	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		return (h ^ {24'd0, b}) * FNV_PRIME;
	endfunction

	function automatic logic [31:0] fold_in(input logic [31:0] acc, input logic [31:0] tag,
			input logic [31:0] h);
		return (acc * FOLD_MULT) ^ (tag * TAG_MULT + h);
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		case (mode)
			M_METHOD: begin
				if (b == CH_SPACE) begin
					tok_fold = fold_in(tok_fold, TAG_METHOD, tok_hash);
					tok_hash = FNV_BASIS;
					mode = M_TARGET;
				end else
					tok_hash = fnv_step(tok_hash, b);
			end
			M_TARGET: begin
				if (b == CH_SPACE) begin
					tok_fold = fold_in(tok_fold, TAG_TARGET, tok_hash);
					mode = M_VERSION;
				end else
					tok_hash = fnv_step(tok_hash, b);
			end
			M_VERSION: begin
				if (b == CH_CR)
					mode = M_LINE_CR;
			end
			M_LINE_CR: mode = (b == CH_LF) ? M_LINE_START : M_BAD;
			M_LINE_START: begin
				if (b == CH_CR)
					mode = M_BLANK_CR;
				else begin
					tok_hash = fnv_step(FNV_BASIS, b);
					mode = M_NAME;
				end
			end
			M_NAME: begin
				if (b == CH_COLON) begin
					tok_fold = fold_in(tok_fold, TAG_NAME, tok_hash);
					mode = M_GAP;
				end else
					tok_hash = fnv_step(tok_hash, b);
			end
			M_GAP: begin
				// empty value: CR straight after colon and spaces folds nothing
				if (b == CH_CR)
					mode = M_LINE_CR;
				else if (b != CH_SPACE) begin
					tok_hash = fnv_step(FNV_BASIS, b);
					mode = M_VALUE;
				end
			end
			M_VALUE: begin
				if (b == CH_CR) begin
					tok_fold = fold_in(tok_fold, TAG_VALUE, tok_hash);
					mode = M_LINE_CR;
				end else
					tok_hash = fnv_step(tok_hash, b);
			end
			M_BLANK_CR: mode = (b == CH_LF) ? M_DONE : M_BAD;
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		head_result_t got;
		head_result_t want;
		if (!arst_n) begin
			mode = M_METHOD;
			tok_hash = FNV_BASIS;
			tok_fold = '0;
			sum_total = '0;
			errs = 0;
			head_results.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result side first: a head's result never leaves on its own last transfer
			if (out_valid && !out_stall) begin
				got.checksum = head_checksum;
				got.complete = head_complete;
				got.total = running_total;
				if (head_results.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result transfer with none outstanding: sum %h cpl %b tot %h",
							$realtime, got.checksum, got.complete, got.total);
				end else begin
					want = head_results.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10)
							$display("%0t: mismatch sum %h/%h cpl %b/%b tot %h/%h (exp/act)",
								$realtime, want.checksum, got.checksum, want.complete,
								got.complete, want.total, got.total);
					end
				end
			end
			if (in_valid && !in_stall) begin
				parse_byte(head_byte);
				if (last_byte) begin
					want.complete = (mode == M_DONE);
					want.checksum = want.complete ? tok_fold : '0;
					sum_total = sum_total + want.checksum;
					want.total = sum_total;
					head_results.push_back(want);
					mode = M_METHOD;
					tok_hash = FNV_BASIS;
					tok_fold = '0;
				end
			end
			fail_count <= errs;
			pending <= head_results.size();
		end
	end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Feeds the request head hasher directed heads, then random well-formed,
// truncated, corrupted and noise heads under four idle/stall mixes, and
// reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
	import hhth_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  head_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [31:0] head_checksum;
	logic        head_complete;
	logic [31:0] running_total;
	int          fail_count;
	int          pending;

	int          send_idle = 0;
	int          recv_stall = 0;
	logic [7:0]  head_bytes[$];

	always #4 clk = ~clk;

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall);

	http_head_token_hasher_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.head_byte     (head_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.head_checksum (head_checksum),
		.head_complete (head_complete),
		.running_total (running_total)
	);

	hhth_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.head_byte     (head_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.head_checksum (head_checksum),
		.head_complete (head_complete),
		.running_total (running_total),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		head_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic send_head();
		foreach (head_bytes[i])
			send_byte(head_bytes[i], i == head_bytes.size() - 1);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_SPACE || b == CH_CR || b == CH_LF || b == CH_COLON);
		return b;
	endfunction

	task automatic push_plain(input int n);
		repeat (n)
			head_bytes.push_back(plain_byte());
	endtask

	task automatic push_crlf();
		head_bytes.push_back(CH_CR);
		head_bytes.push_back(CH_LF);
	endtask

	// mostly well-formed heads; some truncated, some with a broken line end, some noise
	task automatic build_head();
		int kind;
		int n;
		int pick;
		int lf_at[$];
		head_bytes.delete();
		kind = $urandom_range(9);
		if (kind == 9) begin
			n = $urandom_range(1, 16);
			repeat (n)
				case ($urandom_range(5))
					0: head_bytes.push_back(CH_SPACE);
					1: head_bytes.push_back(CH_CR);
					2: head_bytes.push_back(CH_LF);
					3: head_bytes.push_back(CH_COLON);
					default: head_bytes.push_back(8'($urandom_range(255)));
				endcase
			return;
		end
		push_plain($urandom_range(1, 5));
		head_bytes.push_back(CH_SPACE);
		push_plain($urandom_range(0, 6));
		head_bytes.push_back(CH_SPACE);
		push_plain($urandom_range(0, 8));
		push_crlf();
		repeat ($urandom_range(3)) begin
			push_plain($urandom_range(1, 5));
			head_bytes.push_back(CH_COLON);
			repeat ($urandom_range(2))
				head_bytes.push_back(CH_SPACE);
			n = $urandom_range(0, 6);
			if (n > 0) begin
				push_plain(1);
				repeat (n - 1)
					head_bytes.push_back(($urandom_range(3) == 0) ? CH_SPACE : plain_byte());
			end
			push_crlf();
		end
		push_crlf();
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(1, 2))
				head_bytes.push_back(8'($urandom_range(255)));
		if (kind == 7) begin
			n = $urandom_range(1, head_bytes.size() - 1);
			while (head_bytes.size() > n)
				void'(head_bytes.pop_back());
		end else if (kind == 8) begin
			foreach (head_bytes[i])
				if (head_bytes[i] == CH_LF)
					lf_at.push_back(i);
			pick = lf_at[$urandom_range(lf_at.size() - 1)];
			do
				head_bytes[pick] = 8'($urandom_range(255));
			while (head_bytes[pick] == CH_LF);
		end
	endtask

	initial begin
		int n_bytes;
		int n_heads;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme bytes as tokens, empty version, trailing byte after the blank line
		head_bytes = '{8'hFF, CH_SPACE, 8'h00, CH_SPACE, CH_CR, CH_LF, CH_CR, CH_LF, 8'h7F};
		send_head();
		// header with an empty value
		head_bytes = '{8'h47, CH_SPACE, 8'h2F, CH_SPACE, CH_CR, CH_LF, 8'h6E, CH_COLON,
			CH_SPACE, CH_CR, CH_LF, CH_CR, CH_LF};
		send_head();
		// CR without LF after the request line
		head_bytes = '{8'h50, CH_SPACE, CH_SPACE, CH_CR, CH_SPACE};
		send_head();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall <= 0;  end
				1: begin send_idle = 81; recv_stall <= 0;  end
				2: begin send_idle = 0;  recv_stall <= 81; end
				default: begin send_idle = 35; recv_stall <= 35; end
			endcase
			n_bytes = 0;
			n_heads = 0;
			while (n_bytes < 190 || n_heads < 5) begin
				build_head();
				n_bytes += head_bytes.size();
				n_heads++;
				send_head();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
